FILE: hw/rtl/cpf_pkg.sv
// cpf_pkg: shared types, codes and sizes for the face-list to CSR pattern builder.
// No dependencies; used by the top level and the port checker.
package cpf_pkg;

	localparam int MAX_CELLS = 1024;
	localparam int MAX_FACES = 4096;
	localparam int NNZ_CAP   = MAX_CELLS + 2 * MAX_FACES;

	localparam int CELL_W  = $clog2(MAX_CELLS);      // cell index
	localparam int NCELL_W = $clog2(MAX_CELLS + 1);  // cell count
	localparam int FACE_AW = $clog2(MAX_FACES);      // face index
	localparam int CNT_W   = 13;                     // face count / row fill
	localparam int NNZ_W   = 14;                     // pattern index
	localparam int SLOT_W  = 8;

	// request codes
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_BUILD = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// table codes
	localparam logic [2:0] TBL_ROW   = 3'd0;
	localparam logic [2:0] TBL_COL   = 3'd1;
	localparam logic [2:0] TBL_OWN   = 3'd2;
	localparam logic [2:0] TBL_NEI   = 3'd3;
	localparam logic [2:0] TBL_DIAG  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [CELL_W-1:0]  owner_cell;
		logic [CELL_W-1:0]  neighbour_cell;
		logic [2:0]         table_sel;
		logic [NNZ_W-1:0]   entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [NNZ_W-1:0]   read_value;
		logic [CNT_W-1:0]   face_total;
		logic [NNZ_W-1:0]   nonzero_total;
	} rsp_t;

endpackage

FILE: hw/rtl/csr_pattern_from_face_list_top.sv
// csr_pattern_from_face_list_top: loads faces and builds a CSR pattern in on-chip memories.
// Depends on cpf_pkg.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------
//  request   | start / busy           | req   (cpf_pkg::req_t)
//  result    | done (one-cycle strobe)| rsp   (cpf_pkg::rsp_t)
//  config    | APB psel/penable/pwrite| num_cells (paddr not decoded)
//
// Clear and add answer in the next cycle and may follow back to back. A read registers
// the memory output, then passes through S_RD, which registers the result. A build
// walks the face and cell memories: it checks the stored faces, sets the row fills,
// counts row entries, forms row offsets, then places lower, diagonal, upper entries.
// Reset clears the face count and the built flag; the memories are not cleared.
// The result cannot be stalled: done is high for exactly one cycle per item.
module csr_pattern_from_face_list_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cpf_pkg::req_t        req,
	output logic                 done,
	output cpf_pkg::rsp_t        rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [4:0] {
		S_IDLE, S_RD,
		S_CHK_A, S_CHK_D,
		S_INIT,
		S_CNT_A, S_CNT_O, S_CNT_OW, S_CNT_N, S_CNT_NW,
		S_PFX_A, S_PFX_D,
		S_LOW_F, S_LOW_A, S_LOW_D,
		S_DIA_A, S_DIA_D,
		S_UP_F, S_UP_A, S_UP_D
	} state_t;

	state_t state_q;

	logic [cpf_pkg::NCELL_W-1:0] ncell_q;
	logic [cpf_pkg::CNT_W-1:0]   faces_q;
	logic                        built_q;
	logic [cpf_pkg::CNT_W-1:0]   f_q;
	logic [cpf_pkg::NCELL_W-1:0] c_q;
	logic [cpf_pkg::NNZ_W-1:0]   acc_q;
	logic [1:0]                  st_q;
	logic [cpf_pkg::CELL_W-1:0]  own_q, nei_q;
	logic [2:0]                  sel_q;
	logic                        rd_ok_q;
	logic                        done_q;
	cpf_pkg::rsp_t               rsp_q;

	// memories
	logic [cpf_pkg::CELL_W-1:0]  face_own_mem [cpf_pkg::MAX_FACES];
	logic [cpf_pkg::CELL_W-1:0]  face_nei_mem [cpf_pkg::MAX_FACES];
	logic [cpf_pkg::CNT_W-1:0]   fill_mem     [cpf_pkg::MAX_CELLS];
	logic [cpf_pkg::NNZ_W-1:0]   rstart_mem   [cpf_pkg::MAX_CELLS + 1];
	logic [cpf_pkg::CELL_W-1:0]  col_mem      [cpf_pkg::NNZ_CAP];
	logic [cpf_pkg::SLOT_W-1:0]  oslot_mem    [cpf_pkg::MAX_FACES];
	logic [cpf_pkg::SLOT_W-1:0]  nslot_mem    [cpf_pkg::MAX_FACES];
	logic [cpf_pkg::SLOT_W-1:0]  dslot_mem    [cpf_pkg::MAX_CELLS];

	logic [cpf_pkg::CELL_W-1:0]  fo_rd, fn_rd, col_rd;
	logic [cpf_pkg::CNT_W-1:0]   fill_rd;
	logic [cpf_pkg::NNZ_W-1:0]   rs_rd;
	logic [cpf_pkg::SLOT_W-1:0]  os_rd, ns_rd, ds_rd;

	logic [cpf_pkg::FACE_AW-1:0] face_raddr, slot_raddr, face_waddr;
	logic [cpf_pkg::CELL_W-1:0]  fill_raddr, fill_waddr, dslot_raddr;
	logic [cpf_pkg::CNT_W-1:0]   fill_wdata;
	logic                        fill_we;
	logic [cpf_pkg::NCELL_W-1:0] rs_raddr, rs_waddr;
	logic [cpf_pkg::NNZ_W-1:0]   rs_wdata;
	logic                        rs_we;
	logic [cpf_pkg::NNZ_W-1:0]   col_raddr, col_waddr;
	logic [cpf_pkg::CELL_W-1:0]  col_wdata;
	logic                        col_we, face_we;

	logic                        accept, cfg_wr;
	logic [cpf_pkg::NCELL_W-1:0] n;
	logic [cpf_pkg::NNZ_W-1:0]   nnz;
	logic                        last_f, last_c;
	logic [cpf_pkg::CNT_W-1:0]   fill_inc;
	logic [cpf_pkg::NNZ_W-1:0]   pfx_sum, col_slot_addr;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {{(32 - cpf_pkg::NCELL_W){1'b0}}, ncell_q};

	// clamped cell count and pattern size
	always_comb begin
		if (ncell_q == '0) begin
			n = cpf_pkg::NCELL_W'(1);
		end else if (ncell_q > cpf_pkg::NCELL_W'(cpf_pkg::MAX_CELLS)) begin
			n = cpf_pkg::NCELL_W'(cpf_pkg::MAX_CELLS);
		end else begin
			n = ncell_q;
		end
	end
	assign nnz = cpf_pkg::NNZ_W'(n) + {faces_q, 1'b0};

	assign last_f   = (f_q + cpf_pkg::CNT_W'(1)) == faces_q;
	assign last_c   = (c_q + cpf_pkg::NCELL_W'(1)) == n;
	assign fill_inc = fill_rd + cpf_pkg::CNT_W'(1);
	assign pfx_sum  = acc_q + cpf_pkg::NNZ_W'(fill_rd);
	assign col_slot_addr = rs_rd + cpf_pkg::NNZ_W'(fill_rd);

	// memory address and write selection
	always_comb begin
		face_raddr  = f_q[cpf_pkg::FACE_AW-1:0];
		face_waddr  = faces_q[cpf_pkg::FACE_AW-1:0];
		face_we     = accept && (req.req_type == cpf_pkg::REQ_ADD)
			&& ({1'b0, req.owner_cell} < n) && ({1'b0, req.neighbour_cell} < n)
			&& (faces_q < cpf_pkg::CNT_W'(cpf_pkg::MAX_FACES));
		slot_raddr  = req.entry_index[cpf_pkg::FACE_AW-1:0];
		dslot_raddr = req.entry_index[cpf_pkg::CELL_W-1:0];
		col_raddr   = req.entry_index;
		fill_raddr  = c_q[cpf_pkg::CELL_W-1:0];
		fill_waddr  = c_q[cpf_pkg::CELL_W-1:0];
		fill_wdata  = '0;
		fill_we     = 1'b0;
		rs_raddr    = req.entry_index[cpf_pkg::NCELL_W-1:0];
		rs_waddr    = '0;
		rs_wdata    = '0;
		rs_we       = 1'b0;
		col_waddr   = col_slot_addr;
		col_wdata   = own_q;
		col_we      = 1'b0;
		unique case (state_q)
			S_INIT: begin
				fill_wdata = cpf_pkg::CNT_W'(1);
				fill_we    = 1'b1;
				rs_we      = (c_q == '0);
			end
			S_CNT_O:  fill_raddr = fo_rd;
			S_CNT_OW: begin
				fill_waddr = own_q;
				fill_wdata = fill_inc;
				fill_we    = 1'b1;
			end
			S_CNT_N:  fill_raddr = nei_q;
			S_CNT_NW: begin
				fill_waddr = nei_q;
				fill_wdata = fill_inc;
				fill_we    = 1'b1;
			end
			S_PFX_D: begin
				fill_we  = 1'b1;
				rs_waddr = c_q + cpf_pkg::NCELL_W'(1);
				rs_wdata = pfx_sum;
				rs_we    = 1'b1;
			end
			S_LOW_A: begin
				fill_raddr = fn_rd;
				rs_raddr   = {1'b0, fn_rd};
			end
			S_LOW_D: begin
				fill_waddr = nei_q;
				fill_wdata = fill_inc;
				fill_we    = 1'b1;
				col_wdata  = own_q;
				col_we     = 1'b1;
			end
			S_DIA_A: rs_raddr = c_q;
			S_DIA_D: begin
				fill_wdata = fill_inc;
				fill_we    = 1'b1;
				col_wdata  = c_q[cpf_pkg::CELL_W-1:0];
				col_we     = 1'b1;
			end
			S_UP_A: begin
				fill_raddr = fo_rd;
				rs_raddr   = {1'b0, fo_rd};
			end
			S_UP_D: begin
				fill_waddr = own_q;
				fill_wdata = fill_inc;
				fill_we    = 1'b1;
				col_wdata  = nei_q;
				col_we     = 1'b1;
			end
			default: ;
		endcase
	end

	// face store
	always_ff @(posedge clk) begin
		if (face_we) begin
			face_own_mem[face_waddr] <= req.owner_cell;
			face_nei_mem[face_waddr] <= req.neighbour_cell;
		end
		fo_rd <= face_own_mem[face_raddr];
		fn_rd <= face_nei_mem[face_raddr];
	end

	// row fill counts
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rd <= fill_mem[fill_raddr];
	end

	// row offsets
	always_ff @(posedge clk) begin
		if (rs_we) begin
			rstart_mem[rs_waddr] <= rs_wdata;
		end
		rs_rd <= rstart_mem[rs_raddr];
	end

	// column indices
	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
		col_rd <= col_mem[col_raddr];
	end

	// slot tables
	always_ff @(posedge clk) begin
		if (state_q == S_LOW_D) begin
			nslot_mem[f_q[cpf_pkg::FACE_AW-1:0]] <= fill_rd[cpf_pkg::SLOT_W-1:0];
		end
		if (state_q == S_UP_D) begin
			oslot_mem[f_q[cpf_pkg::FACE_AW-1:0]] <= fill_rd[cpf_pkg::SLOT_W-1:0];
		end
		if (state_q == S_DIA_D) begin
			dslot_mem[c_q[cpf_pkg::CELL_W-1:0]] <= fill_rd[cpf_pkg::SLOT_W-1:0];
		end
		os_rd <= oslot_mem[slot_raddr];
		ns_rd <= nslot_mem[slot_raddr];
		ds_rd <= dslot_mem[dslot_raddr];
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ncell_q <= cpf_pkg::NCELL_W'(cpf_pkg::MAX_CELLS);
			faces_q <= '0;
			built_q <= 1'b0;
			done_q  <= 1'b0;
			f_q     <= '0;
			c_q     <= '0;
			acc_q   <= '0;
			st_q    <= cpf_pkg::ST_OK;
			sel_q   <= '0;
			rd_ok_q <= 1'b0;
			own_q   <= '0;
			nei_q   <= '0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				ncell_q <= pwdata[cpf_pkg::NCELL_W-1:0];
				built_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_q.read_value <= '0;
						rsp_q.status     <= cpf_pkg::ST_OK;
						rsp_q.face_total <= faces_q;
						rsp_q.nonzero_total <= built_q ? nnz : '0;
						f_q   <= '0;
						c_q   <= '0;
						acc_q <= '0;
						st_q  <= cpf_pkg::ST_OK;
						unique case (req.req_type)
							cpf_pkg::REQ_CLEAR: begin
								faces_q <= '0;
								built_q <= 1'b0;
								rsp_q.face_total    <= '0;
								rsp_q.nonzero_total <= '0;
								done_q  <= 1'b1;
							end
							cpf_pkg::REQ_ADD: begin
								done_q <= 1'b1;
								if (!face_we) begin
									rsp_q.status <= (({1'b0, req.owner_cell} >= n)
										|| ({1'b0, req.neighbour_cell} >= n))
										? cpf_pkg::ST_RANGE : cpf_pkg::ST_FULL;
								end else begin
									faces_q <= faces_q + cpf_pkg::CNT_W'(1);
									built_q <= 1'b0;
									rsp_q.face_total    <= faces_q + cpf_pkg::CNT_W'(1);
									rsp_q.nonzero_total <= '0;
								end
							end
							cpf_pkg::REQ_BUILD: begin
								state_q <= (faces_q == '0) ? S_INIT : S_CHK_A;
							end
							cpf_pkg::REQ_READ: begin
								sel_q   <= req.table_sel;
								rd_ok_q <= built_q && (
									((req.table_sel == cpf_pkg::TBL_ROW)
										&& (req.entry_index <= cpf_pkg::NNZ_W'(n)))
									|| ((req.table_sel == cpf_pkg::TBL_COL)
										&& (req.entry_index < nnz))
									|| (((req.table_sel == cpf_pkg::TBL_OWN)
										|| (req.table_sel == cpf_pkg::TBL_NEI))
										&& (req.entry_index < cpf_pkg::NNZ_W'(faces_q)))
									|| ((req.table_sel == cpf_pkg::TBL_DIAG)
										&& (req.entry_index < cpf_pkg::NNZ_W'(n))));
								state_q <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (rd_ok_q) begin
						rsp_q.status <= cpf_pkg::ST_OK;
						unique case (sel_q)
							cpf_pkg::TBL_ROW:  rsp_q.read_value <= rs_rd;
							cpf_pkg::TBL_COL:  rsp_q.read_value <= cpf_pkg::NNZ_W'(col_rd);
							cpf_pkg::TBL_OWN:  rsp_q.read_value <= cpf_pkg::NNZ_W'(os_rd);
							cpf_pkg::TBL_NEI:  rsp_q.read_value <= cpf_pkg::NNZ_W'(ns_rd);
							default:           rsp_q.read_value <= cpf_pkg::NNZ_W'(ds_rd);
						endcase
					end else begin
						rsp_q.status <= cpf_pkg::ST_RANGE;
					end
				end
				// stale face check
				S_CHK_A: state_q <= S_CHK_D;
				S_CHK_D: begin
					if (({1'b0, fo_rd} >= n) || ({1'b0, fn_rd} >= n)) begin
						rsp_q.status <= cpf_pkg::ST_RANGE;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (last_f) begin
						f_q     <= '0;
						state_q <= S_INIT;
					end else begin
						f_q     <= f_q + cpf_pkg::CNT_W'(1);
						state_q <= S_CHK_A;
					end
				end
				// every row starts with one entry for the diagonal
				S_INIT: begin
					if (last_c) begin
						c_q     <= '0;
						state_q <= (faces_q == '0) ? S_PFX_A : S_CNT_A;
					end else begin
						c_q <= c_q + cpf_pkg::NCELL_W'(1);
					end
				end
				// count entries per row
				S_CNT_A: state_q <= S_CNT_O;
				S_CNT_O: begin
					own_q   <= fo_rd;
					nei_q   <= fn_rd;
					state_q <= S_CNT_OW;
				end
				S_CNT_OW: state_q <= S_CNT_N;
				S_CNT_N:  state_q <= S_CNT_NW;
				S_CNT_NW: begin
					if (last_f) begin
						f_q     <= '0;
						state_q <= S_PFX_A;
					end else begin
						f_q     <= f_q + cpf_pkg::CNT_W'(1);
						state_q <= S_CNT_A;
					end
				end
				// running sum into the row offsets, fill reset to zero
				S_PFX_A: state_q <= S_PFX_D;
				S_PFX_D: begin
					if (fill_rd > cpf_pkg::CNT_W'(256)) begin
						st_q <= cpf_pkg::ST_LONG;
					end
					acc_q <= pfx_sum;
					if (last_c) begin
						c_q     <= '0;
						state_q <= (faces_q == '0) ? S_DIA_A : S_LOW_F;
					end else begin
						c_q     <= c_q + cpf_pkg::NCELL_W'(1);
						state_q <= S_PFX_A;
					end
				end
				// lower entries, face order
				S_LOW_F: state_q <= S_LOW_A;
				S_LOW_A: begin
					own_q   <= fo_rd;
					nei_q   <= fn_rd;
					state_q <= S_LOW_D;
				end
				S_LOW_D: begin
					if (last_f) begin
						f_q     <= '0;
						state_q <= S_DIA_A;
					end else begin
						f_q     <= f_q + cpf_pkg::CNT_W'(1);
						state_q <= S_LOW_F;
					end
				end
				// diagonal entries
				S_DIA_A: state_q <= S_DIA_D;
				S_DIA_D: begin
					if (last_c) begin
						c_q <= '0;
						if (faces_q == '0) begin
							built_q <= 1'b1;
							rsp_q.status <= st_q;
							rsp_q.nonzero_total <= nnz;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_UP_F;
						end
					end else begin
						c_q     <= c_q + cpf_pkg::NCELL_W'(1);
						state_q <= S_DIA_A;
					end
				end
				// upper entries, face order
				S_UP_F: state_q <= S_UP_A;
				S_UP_A: begin
					own_q   <= fo_rd;
					nei_q   <= fn_rd;
					state_q <= S_UP_D;
				end
				S_UP_D: begin
					if (last_f) begin
						built_q <= 1'b1;
						rsp_q.status <= st_q;
						rsp_q.nonzero_total <= nnz;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						f_q     <= f_q + cpf_pkg::CNT_W'(1);
						state_q <= S_UP_F;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cpf_checker.sv
// cpf_checker: port-level checks on the CSR pattern builder, bound to its top level.
// Depends on cpf_pkg and csr_pattern_from_face_list_top.
module cpf_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  logic          done,
	input  cpf_pkg::rsp_t rsp
);

	// an accepted item either finishes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item left no trace");

	// a result only follows an accepted item or ongoing work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("result without an item");

	// a read value is only returned with good status
	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.read_value != '0)) |-> (rsp.status == cpf_pkg::ST_OK))
		else $error("value returned with error status");

	// a valid pattern holds one entry per cell plus two per face, so its size exceeds the face count
	a_nnz_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.nonzero_total != '0))
			|-> (rsp.nonzero_total > {1'b0, rsp.face_total}))
		else $error("pattern size below face count");

endmodule

bind csr_pattern_from_face_list_top cpf_checker u_cpf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
